@@ design/tsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

	// default sizing of the counters and the output set
	localparam int MAX_OUTPUTS_DEF = 4;
	localparam int INDEX_BITS_DEF  = 24;

	// field widths fixed by the interface
	localparam int SPLIT_REGS = 4;
	localparam int SIZE_W     = 25;
	localparam int NUM_W      = 3;
	localparam int PORT_W     = 2;
	localparam int OFS_W      = 24;
	localparam int ELEM_W     = 32;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;

	// four segment sizes summed
	localparam int BOUND_W = SIZE_W + 2;

	// divide by three through a reciprocal multiply
	localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;
	localparam int          DIV3_SHIFT = 33;
	localparam int          PROD_W     = SIZE_W + 32;

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// cycles the boundary pipeline needs after a register write
	localparam int SETTLE_CYCLES = 3;
	localparam int SETTLE_W      = 2;

	// register map
	typedef enum logic [2:0] {
		REG_INNER_SIZE     = 3'd0,
		REG_AXIS_LENGTH    = 3'd1,
		REG_NUM_OUTPUTS    = 3'd2,
		REG_EXPLICIT_SPLIT = 3'd3,
		REG_SPLIT_SIZE_0   = 3'd4,
		REG_SPLIT_SIZE_1   = 3'd5,
		REG_SPLIT_SIZE_2   = 3'd6,
		REG_SPLIT_SIZE_3   = 3'd7
	} reg_idx_t;

	// configuration seen by the front
	typedef struct packed {
		logic [SIZE_W-1:0]                  inner_size;
		logic [SIZE_W-1:0]                  axis_length;
		logic [NUM_W-1:0]                   num_outputs;
		logic                               explicit_split;
		logic [SPLIT_REGS-1:0][SIZE_W-1:0]  split_size;
	} cfg_t;

	// classified word passed from front to back
	typedef struct packed {
		logic              hit;
		logic [PORT_W-1:0] port;
		logic [ELEM_W-1:0] elem;
		logic              last;
	} word_t;

	// outputs actually usable: bounded by the split registers
	function automatic int out_limit(input int max_outputs);
		int lim;
		lim = (max_outputs < SPLIT_REGS) ? max_outputs : SPLIT_REGS;
		return lim;
	endfunction

endpackage

`default_nettype wire

@@ design/tensor_split_router_core.sv @@
// Tensor split router: routes a row-major element stream to up to four outputs
// along one split axis.
// Input channel: element and last are taken when push is high and full is low.
// Result channel: while empty is low, output_number, offset and element_out
// hold the oldest routed word; it leaves when pop is high.
// Elements whose axis position lies past the last segment produce no word.
// Configuration goes through the APB port (register i at byte address 4*i).
// The user must write it only while the block is idle; the block itself
// does not enforce this. Throughput is one element per cycle while full is
// low; a routed word passes through the queue and the output register before
// it reaches the result ports. A four-word queue between the classifier and
// the offset stage plus the output register lets either side stall on its
// own; when pop stays low the queue fills and full rises. Segment boundaries
// come from a three-stage pipeline (reciprocal multiply, segment length,
// running sum), so full stays high after reset and after each register write.
// Reset clears all position and offset counters and loads the register
// defaults; a last element clears the counters after it is routed.
`timescale 1ns / 1ps
`default_nettype none

module tensor_split_router_core #(
	parameter int MAX_OUTPUTS = tsr_pkg::MAX_OUTPUTS_DEF,
	parameter int INDEX_BITS  = tsr_pkg::INDEX_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tsr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [tsr_pkg::DATA_W-1:0]  pwdata,
	output logic [tsr_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	// input words
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [tsr_pkg::ELEM_W-1:0]  element,
	input  wire logic                        last,
	// result words
	output logic                             empty,
	input  wire logic                        pop,
	output logic [tsr_pkg::PORT_W-1:0]       output_number,
	output logic [tsr_pkg::OFS_W-1:0]        offset,
	output logic [tsr_pkg::ELEM_W-1:0]       element_out
);
	import tsr_pkg::*;

	cfg_t     cfg_q;
	logic     cfg_wr;
	reg_idx_t reg_idx;
	logic     q_push;
	word_t    q_wdata;
	logic     q_full;
	logic     q_pop;
	word_t    q_rdata;
	logic     q_empty;

	// register decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inner_size     <= SIZE_W'(1);
			cfg_q.axis_length    <= SIZE_W'(1);
			cfg_q.num_outputs    <= NUM_W'(1);
			cfg_q.explicit_split <= 1'b0;
			cfg_q.split_size     <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INNER_SIZE:     cfg_q.inner_size     <= pwdata[SIZE_W-1:0];
				REG_AXIS_LENGTH:    cfg_q.axis_length    <= pwdata[SIZE_W-1:0];
				REG_NUM_OUTPUTS:    cfg_q.num_outputs    <= pwdata[NUM_W-1:0];
				REG_EXPLICIT_SPLIT: cfg_q.explicit_split <= pwdata[0];
				REG_SPLIT_SIZE_0:   cfg_q.split_size[0]  <= pwdata[SIZE_W-1:0];
				REG_SPLIT_SIZE_1:   cfg_q.split_size[1]  <= pwdata[SIZE_W-1:0];
				REG_SPLIT_SIZE_2:   cfg_q.split_size[2]  <= pwdata[SIZE_W-1:0];
				REG_SPLIT_SIZE_3:   cfg_q.split_size[3]  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_INNER_SIZE:     prdata = DATA_W'(cfg_q.inner_size);
			REG_AXIS_LENGTH:    prdata = DATA_W'(cfg_q.axis_length);
			REG_NUM_OUTPUTS:    prdata = DATA_W'(cfg_q.num_outputs);
			REG_EXPLICIT_SPLIT: prdata = DATA_W'(cfg_q.explicit_split);
			REG_SPLIT_SIZE_0:   prdata = DATA_W'(cfg_q.split_size[0]);
			REG_SPLIT_SIZE_1:   prdata = DATA_W'(cfg_q.split_size[1]);
			REG_SPLIT_SIZE_2:   prdata = DATA_W'(cfg_q.split_size[2]);
			REG_SPLIT_SIZE_3:   prdata = DATA_W'(cfg_q.split_size[3]);
			default:            prdata = '0;
		endcase
	end

	// classifier and position counters
	tsr_front #(
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.INDEX_BITS  (INDEX_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cfg_wr  (cfg_wr),
		.push    (push),
		.element (element),
		.last    (last),
		.full    (full),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_word  (q_wdata)
	);

	// decoupling queue
	tsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// offset counters and result register
	tsr_back #(
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.INDEX_BITS  (INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_word        (q_rdata),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.output_number (output_number),
		.offset        (offset),
		.element_out   (element_out)
	);

endmodule

`default_nettype wire

@@ design/tsr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  tsr_pkg::word_t     wdata,
	output logic               full,
	input  wire logic          rd,
	output tsr_pkg::word_t     rdata,
	output logic               empty
);
	import tsr_pkg::*;

	word_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill level stays within depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue fill level above depth");

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("queue written while full");

endmodule

`default_nettype wire

@@ design/tsr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsr_front #(
	parameter int MAX_OUTPUTS = tsr_pkg::MAX_OUTPUTS_DEF,
	parameter int INDEX_BITS  = tsr_pkg::INDEX_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  tsr_pkg::cfg_t                    cfg,
	input  wire logic                        cfg_wr,
	input  wire logic                        push,
	input  wire logic [tsr_pkg::ELEM_W-1:0]  element,
	input  wire logic                        last,
	output logic                             full,
	input  wire logic                        q_full,
	output logic                             q_push,
	output tsr_pkg::word_t                   q_word
);
	import tsr_pkg::*;

	localparam int OUT_LIMIT = out_limit(MAX_OUTPUTS);
	localparam int CW = (INDEX_BITS + 1 > BOUND_W) ? INDEX_BITS + 1 : BOUND_W;
	localparam logic [CW-1:0] SPAN = CW'(64'd1 << INDEX_BITS);

	logic [SETTLE_W-1:0]   settle_q;
	logic                  busy;
	logic [CW-1:0]         eff_inner;
	logic [CW-1:0]         eff_axis_w;
	logic [SIZE_W-1:0]     eff_axis;
	logic [NUM_W-1:0]      n_eff;
	logic [PROD_W-1:0]     prod_s1;
	logic [SIZE_W-1:0]     axis_s1;
	logic [NUM_W-1:0]      n_s1;
	logic [SIZE_W-1:0]     avg_d;
	logic [SIZE_W-1:0]     avg_s2;
	logic [BOUND_W-1:0]    bound_d  [OUT_LIMIT];
	logic [BOUND_W-1:0]    bound_s3 [OUT_LIMIT];
	logic                  hit;
	logic [PORT_W-1:0]     port;
	logic [INDEX_BITS-1:0] inner_q;
	logic [INDEX_BITS-1:0] axis_q;
	logic [CW-1:0]         inner_inc;
	logic [CW-1:0]         axis_inc;

	// sizes clamped to the counter span, output count clamped to the usable range
	assign eff_inner  = (CW'(cfg.inner_size) > SPAN) ? SPAN : CW'(cfg.inner_size);
	assign eff_axis_w = (CW'(cfg.axis_length) > SPAN) ? SPAN : CW'(cfg.axis_length);
	assign eff_axis   = eff_axis_w[SIZE_W-1:0];

	always_comb begin
		if (cfg.num_outputs == '0) begin
			n_eff = NUM_W'(1);
		end else if (cfg.num_outputs > NUM_W'(OUT_LIMIT)) begin
			n_eff = NUM_W'(OUT_LIMIT);
		end else begin
			n_eff = cfg.num_outputs;
		end
	end

	// hold off input while the boundaries catch up with the registers
	assign busy = (settle_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else if (cfg_wr) begin
			settle_q <= SETTLE_W'(SETTLE_CYCLES);
		end else if (busy) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// boundary stage 1: reciprocal multiply for the three-way split
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(eff_axis) * PROD_W'(DIV3_RECIP);
		axis_s1 <= eff_axis;
		n_s1    <= n_eff;
	end

	// boundary stage 2: equal segment length
	always_comb begin
		case (n_s1)
			NUM_W'(2): avg_d = axis_s1 >> 1;
			NUM_W'(3): avg_d = SIZE_W'(prod_s1 >> DIV3_SHIFT);
			NUM_W'(4): avg_d = axis_s1 >> 2;
			default:   avg_d = axis_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		avg_s2 <= avg_d;
	end

	// boundary stage 3: running end of each segment
	always_comb begin
		logic [BOUND_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < OUT_LIMIT; k++) begin
			acc = acc + (cfg.explicit_split ? BOUND_W'(cfg.split_size[k])
			                                : BOUND_W'(avg_s2));
			bound_d[k] = acc;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < OUT_LIMIT; k++) begin
			bound_s3[k] <= bound_d[k];
		end
	end

	// first segment whose end lies past the axis position
	always_comb begin
		hit  = 1'b0;
		port = '0;
		for (int k = OUT_LIMIT - 1; k >= 0; k--) begin
			if ((NUM_W'(k) < n_eff) && (CW'(axis_q) < CW'(bound_s3[k]))) begin
				hit  = 1'b1;
				port = PORT_W'(k);
			end
		end
	end

	assign full   = q_full || busy;
	assign q_push = push && !full;
	assign q_word = '{hit: hit, port: port, elem: element, last: last};

	// row-major position counters
	assign inner_inc = CW'(inner_q) + CW'(1);
	assign axis_inc  = CW'(axis_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			axis_q  <= '0;
		end else if (q_push) begin
			if (last) begin
				inner_q <= '0;
				axis_q  <= '0;
			end else if (inner_inc >= eff_inner) begin
				inner_q <= '0;
				if (axis_inc >= eff_axis_w) begin
					axis_q <= '0;
				end else begin
					axis_q <= INDEX_BITS'(axis_inc);
				end
			end else begin
				inner_q <= INDEX_BITS'(inner_inc);
			end
		end
	end

	// no word enters the queue before the boundaries are valid
	a_settle_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !q_push)
		else $error("word accepted while boundaries settle");

	// a final element restarts the position
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && last) |=> (inner_q == '0 && axis_q == '0))
		else $error("position not cleared after final element");

endmodule

`default_nettype wire

@@ design/tsr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsr_back #(
	parameter int MAX_OUTPUTS = tsr_pkg::MAX_OUTPUTS_DEF,
	parameter int INDEX_BITS  = tsr_pkg::INDEX_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  tsr_pkg::word_t                   q_word,
	input  wire logic                        q_empty,
	output logic                             q_pop,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [tsr_pkg::PORT_W-1:0]       output_number,
	output logic [tsr_pkg::OFS_W-1:0]        offset,
	output logic [tsr_pkg::ELEM_W-1:0]       element_out
);
	import tsr_pkg::*;

	localparam int OUT_LIMIT = out_limit(MAX_OUTPUTS);

	logic [INDEX_BITS-1:0] ofs_q [OUT_LIMIT];
	logic [INDEX_BITS-1:0] ofs_sel;
	logic                  ofs_zero;
	logic                  out_valid_q;
	logic [PORT_W-1:0]     out_port_q;
	logic [OFS_W-1:0]      out_ofs_q;
	logic [ELEM_W-1:0]     out_elem_q;
	logic                  slot_free;
	logic                  load;

	// running offset of the addressed output
	always_comb begin
		ofs_sel  = '0;
		ofs_zero = 1'b1;
		for (int k = 0; k < OUT_LIMIT; k++) begin
			if (q_word.port == PORT_W'(k)) begin
				ofs_sel = ofs_q[k];
			end
			if (ofs_q[k] != '0) begin
				ofs_zero = 1'b0;
			end
		end
	end

	// dropped words retire at once, routed ones wait for the output slot
	assign slot_free = !out_valid_q || pop;
	assign q_pop     = !q_empty && (!q_word.hit || slot_free);
	assign load      = q_pop && q_word.hit;

	// per-output offset counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_LIMIT; k++) begin
				ofs_q[k] <= '0;
			end
		end else if (q_pop) begin
			for (int k = 0; k < OUT_LIMIT; k++) begin
				if (q_word.last) begin
					ofs_q[k] <= '0;
				end else if (q_word.hit && (q_word.port == PORT_W'(k))) begin
					ofs_q[k] <= ofs_q[k] + INDEX_BITS'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_port_q <= q_word.port;
			out_ofs_q  <= OFS_W'(ofs_sel);
			out_elem_q <= q_word.elem;
		end
	end

	assign empty         = !out_valid_q;
	assign output_number = out_port_q;
	assign offset        = out_ofs_q;
	assign element_out   = out_elem_q;

	// every offset restarts after a final element
	a_offsets_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_word.last) |=> ofs_zero)
		else $error("offsets not cleared after final element");

endmodule

`default_nettype wire
